// File: rtl/segment_intersection_point_unit_defines.svh
// assertion macros for the segment intersection unit
`ifndef SEGMENT_INTERSECTION_POINT_UNIT_DEFINES_SVH
`define SEGMENT_INTERSECTION_POINT_UNIT_DEFINES_SVH
// implication checked on every clock edge outside reset
`define SIP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// implication whose consequent is checked in the next cycle
`define SIP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: rtl/sip_pkg.sv
// shared constants for the segment intersection unit
`timescale 1ns / 1ps
`default_nettype none
package sip_pkg;
    localparam int T_BITS = 16;
endpackage
`default_nettype wire

// File: rtl/sip_div_stage.sv
// one restoring division step of the quotient pipeline
`timescale 1ns / 1ps
`default_nettype none
module sip_div_stage
    import sip_pkg::*;
#(
    parameter int DW = 28
)
(
    input  wire logic [DW-1:0]   r_in,
    input  wire logic [DW-1:0]   d_in,
    output logic      [DW-1:0]   r_out,
    output logic                 q_bit
);
    logic [DW:0] r_sh;
    always_comb
    begin
        r_sh = {r_in, 1'b0};
        q_bit = (r_sh >= {1'b0, d_in});
        r_out = q_bit ? DW'(r_sh - {1'b0, d_in}) : DW'(r_sh);
    end
endmodule
`default_nettype wire

// File: rtl/segment_intersection_point_unit.sv
// Segment intersection unit: fully pipelined, accepts one segment pair per cycle while the
// output is not stalled and returns one result per pair, in order. A pair passes through the
// difference, product and sign stages, then the 16-step restoring divider pipeline,
// one quotient bit per stage, and then the multiply and result stages.
// A stall on the output freezes the whole pipe, so in_ready follows out_ready whenever
// a result is waiting.
`timescale 1ns / 1ps
`default_nettype none
`include "segment_intersection_point_unit_defines.svh"
module segment_intersection_point_unit
    import sip_pkg::*;
#(
    parameter int COORD_BITS = 13,
    parameter int FRAC_BITS = 8
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [COORD_BITS-1:0]      a_start_x,
    input  wire logic signed [COORD_BITS-1:0]      a_start_y,
    input  wire logic signed [COORD_BITS-1:0]      a_end_x,
    input  wire logic signed [COORD_BITS-1:0]      a_end_y,
    input  wire logic signed [COORD_BITS-1:0]      b_start_x,
    input  wire logic signed [COORD_BITS-1:0]      b_start_y,
    input  wire logic signed [COORD_BITS-1:0]      b_end_x,
    input  wire logic signed [COORD_BITS-1:0]      b_end_y,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   hit,
    output logic signed [COORD_BITS+FRAC_BITS-1:0] meet_x,
    output logic signed [COORD_BITS+FRAC_BITS-1:0] meet_y
);
    localparam int DB = COORD_BITS + 1;
    localparam int PB = 2 * DB + 1;
    localparam int OB = COORD_BITS + FRAC_BITS;
    localparam int QB = PB + T_BITS + 1;
    localparam int SH = T_BITS - FRAC_BITS;
    localparam int NDIV = T_BITS;

    logic adv;

    // stage 1: differences
    logic              s1_v_reg;
    logic signed [DB-1:0] s1_dax_reg, s1_day_reg, s1_dbx_reg, s1_dby_reg;
    logic signed [DB-1:0] s1_bax_reg, s1_bay_reg, s1_fax_reg, s1_fay_reg;
    logic signed [DB-1:0] s1_abx_reg, s1_aby_reg;
    logic signed [COORD_BITS-1:0] s1_ax_reg, s1_ay_reg;

    // stage 2: cross products
    logic              s2_v_reg;
    logic signed [PB-1:0] s2_o1_reg, s2_o2_reg, s2_o3_reg, s2_o4_reg, s2_num_reg, s2_den_reg;
    logic signed [DB-1:0] s2_dax_reg, s2_day_reg;
    logic signed [COORD_BITS-1:0] s2_ax_reg, s2_ay_reg;

    // stage 3: hit decision and magnitudes
    logic              s3_v_reg, s3_hit_reg, s3_sat_reg;
    logic [PB-1:0]     s3_n_reg, s3_d_reg;
    logic signed [DB-1:0] s3_dax_reg, s3_day_reg;
    logic signed [COORD_BITS-1:0] s3_ax_reg, s3_ay_reg;

    // divider pipeline
    logic              dv_v_reg [NDIV];
    logic              dv_hit_reg [NDIV];
    logic              dv_sat_reg [NDIV];
    logic [PB-1:0]     dv_r_reg [NDIV];
    logic [PB-1:0]     dv_d_reg [NDIV];
    logic [T_BITS-1:0] dv_q_reg [NDIV];
    logic signed [DB-1:0] dv_dax_reg [NDIV], dv_day_reg [NDIV];
    logic signed [COORD_BITS-1:0] dv_ax_reg [NDIV], dv_ay_reg [NDIV];
    logic [PB-1:0]     dv_r_next [NDIV];
    logic              dv_b_next [NDIV];

    // multiply stage
    logic              m_v_reg, m_hit_reg;
    logic signed [QB-1:0] m_px_reg, m_py_reg;

    // result register
    logic              o_v_reg, o_hit_reg;
    logic signed [OB-1:0] o_x_reg, o_y_reg;

    assign adv = !o_v_reg || out_ready;
    assign in_ready = adv;
    assign out_valid = o_v_reg;
    assign hit = o_hit_reg;
    assign meet_x = o_x_reg;
    assign meet_y = o_y_reg;

    function automatic logic signed [1:0] sgn(input logic signed [PB-1:0] v);
        sgn = (v == '0) ? 2'sd0 : (v[PB-1] ? -2'sd1 : 2'sd1);
    endfunction

    function automatic logic signed [OB-1:0] rnd(input logic signed [QB-1:0] v);
        logic signed [QB:0] t;
        t = {v[QB-1], v};
        if (SH > 0)
        begin
            t = t + (QB+1)'(1 << (SH > 0 ? SH - 1 : 0));
        end
        rnd = OB'(t >>> SH);
    endfunction

    function automatic logic signed [DB-1:0] sub(input logic signed [COORD_BITS-1:0] a,
                                                 input logic signed [COORD_BITS-1:0] b);
        sub = DB'(a) - DB'(b);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_dax_reg <= sub(a_end_x, a_start_x);
            s1_day_reg <= sub(a_end_y, a_start_y);
            s1_dbx_reg <= sub(b_end_x, b_start_x);
            s1_dby_reg <= sub(b_end_y, b_start_y);
            s1_bax_reg <= sub(b_start_x, a_start_x);
            s1_bay_reg <= sub(b_start_y, a_start_y);
            s1_fax_reg <= sub(b_end_x, a_start_x);
            s1_fay_reg <= sub(b_end_y, a_start_y);
            s1_abx_reg <= sub(a_end_x, b_start_x);
            s1_aby_reg <= sub(a_end_y, b_start_y);
            s1_ax_reg <= a_start_x;
            s1_ay_reg <= a_start_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            m_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
            for (int i = 0; i < NDIV; i++)
            begin
                dv_v_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            dv_v_reg[0] <= s3_v_reg;
            for (int i = 1; i < NDIV; i++)
            begin
                dv_v_reg[i] <= dv_v_reg[i-1];
            end
            m_v_reg <= dv_v_reg[NDIV-1];
            o_v_reg <= m_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // orientation of B endpoints about A, and A endpoints about B
            s2_o1_reg <= PB'(s1_bax_reg * s1_day_reg) - PB'(s1_bay_reg * s1_dax_reg);
            s2_o2_reg <= PB'(s1_fax_reg * s1_day_reg) - PB'(s1_fay_reg * s1_dax_reg);
            s2_o3_reg <= PB'(s1_bay_reg * s1_dbx_reg) - PB'(s1_bax_reg * s1_dby_reg);
            s2_o4_reg <= PB'(s1_abx_reg * s1_dby_reg) - PB'(s1_aby_reg * s1_dbx_reg);
            s2_num_reg <= PB'(s1_bax_reg * s1_dby_reg) - PB'(s1_bay_reg * s1_dbx_reg);
            s2_den_reg <= PB'(s1_dax_reg * s1_dby_reg) - PB'(s1_day_reg * s1_dbx_reg);
            s2_dax_reg <= s1_dax_reg;
            s2_day_reg <= s1_day_reg;
            s2_ax_reg <= s1_ax_reg;
            s2_ay_reg <= s1_ay_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        logic [PB-1:0] n, d;
        logic h;
        if (adv)
        begin
            n = s2_num_reg[PB-1] ? PB'(-s2_num_reg) : PB'(s2_num_reg);
            d = s2_den_reg[PB-1] ? PB'(-s2_den_reg) : PB'(s2_den_reg);
            h = (sgn(s2_o1_reg) * sgn(s2_o2_reg) < 0) && (sgn(s2_o3_reg) * sgn(s2_o4_reg) < 0)
                && (s2_den_reg != '0);
            s3_hit_reg <= h;
            s3_sat_reg <= (n >= d);
            s3_n_reg <= n;
            s3_d_reg <= d;
            s3_dax_reg <= s2_dax_reg;
            s3_day_reg <= s2_day_reg;
            s3_ax_reg <= s2_ax_reg;
            s3_ay_reg <= s2_ay_reg;
        end
    end

    for (genvar g = 0; g < NDIV; g++)
    begin : g_div
        sip_div_stage #(.DW(PB)) u_stage
        (
            .r_in  (g == 0 ? s3_n_reg : dv_r_reg[g == 0 ? 0 : g-1]),
            .d_in  (g == 0 ? s3_d_reg : dv_d_reg[g == 0 ? 0 : g-1]),
            .r_out (dv_r_next[g]),
            .q_bit (dv_b_next[g])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_r_reg[0] <= dv_r_next[0];
            dv_d_reg[0] <= s3_d_reg;
            dv_q_reg[0] <= T_BITS'(dv_b_next[0]) << (T_BITS - 1);
            dv_hit_reg[0] <= s3_hit_reg;
            dv_sat_reg[0] <= s3_sat_reg;
            dv_dax_reg[0] <= s3_dax_reg;
            dv_day_reg[0] <= s3_day_reg;
            dv_ax_reg[0] <= s3_ax_reg;
            dv_ay_reg[0] <= s3_ay_reg;
            for (int i = 1; i < NDIV; i++)
            begin
                dv_r_reg[i] <= dv_r_next[i];
                dv_d_reg[i] <= dv_d_reg[i-1];
                dv_q_reg[i] <= dv_q_reg[i-1]
                               | (T_BITS'(dv_b_next[i]) << (T_BITS - 1 - i));
                dv_hit_reg[i] <= dv_hit_reg[i-1];
                dv_sat_reg[i] <= dv_sat_reg[i-1];
                dv_dax_reg[i] <= dv_dax_reg[i-1];
                dv_day_reg[i] <= dv_day_reg[i-1];
                dv_ax_reg[i] <= dv_ax_reg[i-1];
                dv_ay_reg[i] <= dv_ay_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        logic [T_BITS-1:0] q;
        if (adv)
        begin
            q = dv_sat_reg[NDIV-1] ? {T_BITS{1'b1}} : dv_q_reg[NDIV-1];
            m_hit_reg <= dv_hit_reg[NDIV-1];
            m_px_reg <= (QB'(dv_ax_reg[NDIV-1]) <<< T_BITS)
                        + QB'(dv_dax_reg[NDIV-1] * $signed({1'b0, q}));
            m_py_reg <= (QB'(dv_ay_reg[NDIV-1]) <<< T_BITS)
                        + QB'(dv_day_reg[NDIV-1] * $signed({1'b0, q}));
            o_hit_reg <= m_hit_reg;
            o_x_reg <= m_hit_reg ? rnd(m_px_reg) : '0;
            o_y_reg <= m_hit_reg ? rnd(m_py_reg) : '0;
        end
    end

    `SIP_ASSERT_IMPL(a_no_hit_zero, clk, rst_n, out_valid && !hit,
        meet_x == '0 && meet_y == '0, "coordinates not zero without hit")
    `SIP_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(meet_x) && $stable(hit), "result changed under stall")
    `SIP_ASSERT_IMPL(a_ready, clk, rst_n, !out_valid, in_ready, "not ready with empty output")
endmodule
`default_nettype wire

// File: test/segment_intersection_point_unit_test.sv
// self-checking testbench for the segment intersection unit
`timescale 1ns / 1ps
`default_nettype none
module segment_intersection_point_unit_test
    import sip_pkg::*;
();

    localparam int COORD_BITS = 13;
    localparam int FRAC_BITS = 8;
    localparam int OUT_BITS = COORD_BITS + FRAC_BITS;
    localparam int RANDOM_REQUESTS = 1100;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 60;
    localparam int N_DIRECTED = 16;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [OUT_BITS-1:0] point_t;

    typedef struct packed {
        coord_t ax, ay, ex, ey, bx, by, fx, fy;
    } segment_pair_t;

    typedef struct packed {
        logic   hit;
        point_t x;
        point_t y;
    } meet_t;

    typedef struct packed {
        segment_pair_t pair;
        logic          known;
        meet_t         res;
    } directed_row_t;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   in_valid = 1'b0;
    logic   in_ready;
    coord_t a_start_x = '0, a_start_y = '0, a_end_x = '0, a_end_y = '0;
    coord_t b_start_x = '0, b_start_y = '0, b_end_x = '0, b_end_y = '0;
    logic   out_valid;
    logic   out_ready = 1'b0;
    logic   hit;
    point_t meet_x, meet_y;

    meet_t         expected_meets[$];
    int            failures = 0;
    int            idle_cycles = 0;
    directed_row_t directed[N_DIRECTED];

    always #1 clk = ~clk;

    segment_intersection_point_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .a_start_x(a_start_x), .a_start_y(a_start_y),
        .a_end_x(a_end_x), .a_end_y(a_end_y),
        .b_start_x(b_start_x), .b_start_y(b_start_y),
        .b_end_x(b_end_x), .b_end_y(b_end_y),
        .out_valid(out_valid), .out_ready(out_ready),
        .hit(hit), .meet_x(meet_x), .meet_y(meet_y)
    );

    function automatic int sign_of(longint v);
        return (v > 0) - (v < 0);
    endfunction

    function automatic longint side_of(longint ox, longint oy, longint px, longint py,
                                       longint qx, longint qy);
        return (qx - ox) * (py - oy) - (qy - oy) * (px - ox);
    endfunction

    // Q16 down to output precision, half up; >>> floors
    function automatic point_t round_point(longint v);
        longint s;
        s = T_BITS - FRAC_BITS;
        if (s <= 0)
            return point_t'(v);
        v = v + (longint'(1) << (s - 1));
        return point_t'(v >>> s);
    endfunction

    function automatic meet_t crossing_point(segment_pair_t p);
        meet_t  m;
        longint ax, ay, ex, ey, bx, by, fx, fy, dax, day, dbx, dby, num, den;
        longint n, d, r, q;
        bit     crosses;
        ax = p.ax; ay = p.ay; ex = p.ex; ey = p.ey;
        bx = p.bx; by = p.by; fx = p.fx; fy = p.fy;
        dax = ex - ax; day = ey - ay; dbx = fx - bx; dby = fy - by;
        crosses = sign_of(side_of(ax, ay, ex, ey, bx, by))
                  * sign_of(side_of(ax, ay, ex, ey, fx, fy)) < 0
               && sign_of(side_of(bx, by, fx, fy, ax, ay))
                  * sign_of(side_of(bx, by, fx, fy, ex, ey)) < 0;
        num = (bx - ax) * dby - (by - ay) * dbx;
        den = dax * dby - day * dbx;
        m = '0;
        if (den == 0 || !crosses)
            return m;
        n = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        q = 0;
        if (n >= d)
            q = (longint'(1) << T_BITS) - 1;
        else
        begin
            r = n;
            for (int i = 0; i < T_BITS; i++)
            begin
                r = r << 1;
                q = q << 1;
                if (r >= d)
                begin
                    r = r - d;
                    q = q | 1;
                end
            end
        end
        m.hit = 1'b1;
        m.x = round_point(ax * (longint'(1) << T_BITS) + dax * q);
        m.y = round_point(ay * (longint'(1) << T_BITS) + day * q);
        return m;
    endfunction

    function automatic coord_t any_coord();
        case ($urandom_range(0, 9))
            0: return coord_t'(-4096);
            1: return coord_t'(4095);
            2, 3: return coord_t'($urandom_range(0, 40)) - coord_t'(20);
            default: return coord_t'($urandom);
        endcase
    endfunction

    // proper crossings mostly: a segment through a random point, and another through it
    function automatic segment_pair_t random_pair();
        segment_pair_t p;
        int            cx, cy, lim;
        int            kind;
        kind = $urandom_range(0, 9);
        lim = ($urandom_range(0, 3) == 0) ? 4000 : 60;
        cx = $urandom_range(0, 2 * lim) - lim;
        cy = $urandom_range(0, 2 * lim) - lim;
        if (kind < 6)
        begin
            int ux, uy, vx, vy, s1, s2, s3, s4;
            ux = $urandom_range(0, 40) - 20; uy = $urandom_range(0, 40) - 20;
            vx = $urandom_range(0, 40) - 20; vy = $urandom_range(0, 40) - 20;
            s1 = $urandom_range(1, 2); s2 = $urandom_range(1, 2);
            s3 = $urandom_range(1, 2); s4 = $urandom_range(1, 2);
            p.ax = coord_t'(cx - s1 * ux); p.ay = coord_t'(cy - s1 * uy);
            p.ex = coord_t'(cx + s2 * ux); p.ey = coord_t'(cy + s2 * uy);
            p.bx = coord_t'(cx - s3 * vx); p.by = coord_t'(cy - s3 * vy);
            p.fx = coord_t'(cx + s4 * vx); p.fy = coord_t'(cy + s4 * vy);
        end
        else
        begin
            p.ax = any_coord(); p.ay = any_coord(); p.ex = any_coord(); p.ey = any_coord();
            p.bx = any_coord(); p.by = any_coord(); p.fx = any_coord(); p.fy = any_coord();
            if (kind == 9)
            begin
                p.bx = p.ax; p.by = p.ay;
            end
        end
        return p;
    endfunction

    function automatic directed_row_t row(int ax, int ay, int ex, int ey, int bx, int by,
                                          int fx, int fy, bit known, bit h, int x, int y);
        directed_row_t t;
        t.pair = {coord_t'(ax), coord_t'(ay), coord_t'(ex), coord_t'(ey),
                  coord_t'(bx), coord_t'(by), coord_t'(fx), coord_t'(fy)};
        t.known = known;
        t.res.hit = h;
        t.res.x = point_t'(x);
        t.res.y = point_t'(y);
        return t;
    endfunction

    task automatic send_request(segment_pair_t p);
        a_start_x <= p.ax; a_start_y <= p.ay; a_end_x <= p.ex; a_end_y <= p.ey;
        b_start_x <= p.bx; b_start_y <= p.by; b_end_x <= p.fx; b_end_y <= p.fy;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic sender_gap();
        int gap;
        gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // sampled at the edge the dut also sees; expectation queued on acceptance
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            expected_meets.push_back(crossing_point({a_start_x, a_start_y, a_end_x, a_end_y,
                                                    b_start_x, b_start_y, b_end_x, b_end_y}));
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_meets.size() == 0)
            begin
                $error("unexpected result hit=%0b x=%0d y=%0d", hit, meet_x, meet_y);
                failures++;
            end
            else
            begin
                meet_t e;
                e = expected_meets.pop_front();
                if (hit !== e.hit)
                begin
                    $error("hit expected %0b actual %0b", e.hit, hit);
                    failures++;
                end
                if (meet_x !== e.x)
                begin
                    $error("meet_x expected %0d actual %0d", e.x, meet_x);
                    failures++;
                end
                if (meet_y !== e.y)
                begin
                    $error("meet_y expected %0d actual %0d", e.y, meet_y);
                    failures++;
                end
            end
        end
    end

    // receiver stall pattern, with quiet stretches
    always @(posedge clk)
    begin
        int phase;
        phase = ($time / 400) % 3;
        if (phase == 0)
            out_ready <= 1'b1;
        else if (phase == 1)
            out_ready <= ($urandom_range(0, 3) != 0);
        else
            out_ready <= ($urandom_range(0, 1) == 0);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int drain;
        directed[0]  = row(0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
        directed[1]  = row(-10, 0, 10, 0, 0, -10, 0, 10, 1, 1, 0, 0);
        directed[2]  = row(-4096, -4096, 4095, 4095, -4096, 4095, 4095, -4096, 0, 0, 0, 0);
        directed[3]  = row(4095, -4096, -4096, 4095, -4096, -4096, 4095, 4095, 0, 0, 0, 0);
        directed[4]  = row(0, 0, 10, 0, 5, 0, 5, 10, 1, 0, 0, 0);
        directed[5]  = row(0, 0, 10, 0, 10, 0, 20, 5, 1, 0, 0, 0);
        directed[6]  = row(0, 0, 10, 0, 2, 0, 8, 0, 1, 0, 0, 0);
        directed[7]  = row(0, 0, 10, 0, 0, 5, 10, 5, 1, 0, 0, 0);
        directed[8]  = row(0, 0, 10, 0, 20, -5, 20, 5, 1, 0, 0, 0);
        directed[9]  = row(0, 0, 3, 3, 0, 1, 1, 0, 0, 0, 0, 0);
        directed[10] = row(-4096, 0, 4095, 0, 0, -4096, 0, 4095, 0, 0, 0, 0);
        directed[11] = row(0, 0, 3, 0, 1, -1, 1, 1, 0, 0, 0, 0);
        directed[12] = row(-3, -7, 5, 9, 4, -8, -6, 2, 0, 0, 0, 0);
        directed[13] = row(4095, 4095, -4096, -4096, 4095, -4096, -4096, 4095, 0, 0, 0, 0);
        directed[14] = row(0, 0, 1, 1, 0, 1, 1, 0, 0, 0, 0, 0);
        directed[15] = row(1, 0, -1, 0, 0, 1, 0, -1, 0, 0, 0, 0);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (directed[i].known && crossing_point(directed[i].pair) !== directed[i].res)
            begin
                $error("directed row %0d disagrees with typed-in result", i);
                failures++;
            end
            send_request(directed[i].pair);
        end
        in_valid <= 1'b0;
        while (expected_meets.size() != 0)
            @(posedge clk);
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            int burst;
            burst = $urandom_range(1, 30);
            for (int j = 0; j < burst && i < RANDOM_REQUESTS; j++, i++)
                send_request(random_pair());
            i--;
            sender_gap();
        end
        in_valid <= 1'b0;
        drain = 0;
        while (expected_meets.size() != 0 && drain < 100000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && expected_meets.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire

// File: segment_intersection_point_unit.f
+incdir+rtl
rtl/sip_pkg.sv
rtl/sip_div_stage.sv
rtl/segment_intersection_point_unit.sv
test/segment_intersection_point_unit_test.sv
